[rtl/synth_voice_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_UNIT_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SVA_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define SVA_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SVA_IMPLIES(label, ante, cons)
`define SVA_NEXT(label, ante, cons)

`endif

`endif

[rtl/svau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svau_pkg
// Shared types and constants of the voice allocator.
// ----------------------------------------------------------------------------
package svau_pkg;

    localparam int VOICE_COUNT_DEF    = 8;
    localparam int SUSTAIN_CONTROLLER = 64;
    localparam int STEAL_CONTROLLER   = 80;

    localparam int IN_TDATA_W  = 64;
    localparam int IN_USED_W   = 59;
    localparam int OUT_TDATA_W = 32;
    localparam int EVENT_W     = 3;

    // upper nibble of the status byte
    localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
    localparam logic [3:0] MSG_CONTROL  = 4'hB;

    typedef enum logic [2:0] {
        VS_IDLE       = 3'd0,
        VS_STARTING   = 3'd1,
        VS_RUNNING    = 3'd2,
        VS_RESTARTING = 3'd3,
        VS_STOPPED    = 3'd4,
        VS_RELEASED   = 3'd5
    } t_voice_state;

    typedef enum logic [2:0] {
        EV_IGNORED    = 3'd0,
        EV_ASSIGNED   = 3'd1,
        EV_RELEASED   = 3'd2,
        EV_CONTROLLER = 3'd3,
        EV_TICKED     = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        IK_NONE,
        IK_NOTE_ON,
        IK_NOTE_OFF,
        IK_CONTROL,
        IK_TICK
    } t_item_kind;

    typedef struct packed {
        t_voice_state state;
        logic [6:0]   note;
        logic [6:0]   pend_note;
        logic [6:0]   pend_vel;
        logic [31:0]  age;
    } t_voice_entry;

    typedef struct packed {
        logic load_item;    // capture the input transfer
        logic scan_clear;   // restart voice scan
        logic scan_read;    // read voice at scan pointer
        logic target_read;  // read ticked or picked voice
        logic commit;       // write back and load result
    } t_dp_cmd;

    typedef struct packed {
        t_item_kind kind;
        logic       scan_last;
        logic       out_busy;
    } t_dp_status;

endpackage

[rtl/svau_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svau_ctrl
// Sequencer: takes one item, walks the voice scan for note items and commits the result.
// ----------------------------------------------------------------------------
module svau_ctrl
    import svau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SCAN_END,
        S_PICK,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.kind) inside
                    IK_NOTE_ON, IK_NOTE_OFF: begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = S_SCAN;
                    end
                    IK_TICK: begin
                        o_cmd.target_read = 1'b1;
                        n_state           = S_COMMIT;
                    end
                    default: begin
                        n_state = S_COMMIT;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                // last entry is evaluated in this cycle
                n_state = (i_status.kind == IK_NOTE_ON) ? S_PICK : S_COMMIT;
            end
            S_PICK: begin
                o_cmd.target_read = 1'b1;
                n_state           = S_COMMIT;
            end
            S_COMMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

[rtl/svau_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svau_datapath
// Item latch, voice store, scan accumulators, tick update and result register.
// ----------------------------------------------------------------------------
module svau_datapath
    import svau_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  logic [IN_USED_W-1:0]   i_item_data,
    input  logic                   i_item_user,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic [EVENT_W-1:0]     o_out_user
);

    localparam int VI_W = $clog2(VOICE_COUNT);
    localparam logic [VI_W-1:0] LAST_VOICE = VI_W'(VOICE_COUNT - 1);

    // latched item
    logic        r_cmd;
    logic [3:0]  r_msg;
    logic [6:0]  r_d1;
    logic [6:0]  r_d2;
    logic [2:0]  r_vidx;
    logic        r_tailed;
    logic [31:0] r_pos;

    logic [6:0]  r_sustain;
    logic [6:0]  r_steal;

    // voice store
    t_voice_entry           r_mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] r_valid;
    t_voice_entry           r_rd_data;
    logic                   r_rd_valid;
    t_voice_entry           entry;

    // scan
    logic [VI_W-1:0] r_scan_idx;
    logic            r_eval;
    logic [VI_W-1:0] r_eval_idx;
    logic            r_idle_found;
    logic [VI_W-1:0] r_idle_idx;
    logic            r_same_found;
    logic [VI_W-1:0] r_same_idx;
    logic            r_old_found;
    logic [VI_W-1:0] r_old_idx;
    logic [31:0]     r_old_age;
    logic [7:0]      r_mask;

    t_item_kind      kind;
    logic            busy;
    logic            note_hit;
    logic [VI_W-1:0] pick;
    logic            stolen;
    logic [VI_W-1:0] target_addr;
    logic            rd_en;
    logic [VI_W-1:0] rd_addr;
    logic            wr_en;
    logic [VI_W-1:0] wr_addr;
    t_voice_entry    wr_data;

    t_voice_entry tk_next;
    logic         tk_start;
    logic         tk_rel;

    // result fields
    t_event     res_event;
    logic [2:0] res_voice;
    logic       res_stolen;
    logic [7:0] res_mask;
    logic       res_quick;
    logic       res_start;
    logic       res_rel;
    logic [2:0] res_state;
    logic [6:0] res_note;
    logic [6:0] res_vel;

    logic r_out_valid;

    // ---------------- item latch ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd    <= i_item_user;
            r_msg    <= i_item_data[7:4];
            r_d1     <= i_item_data[14:8];
            r_d2     <= i_item_data[21:15];
            r_vidx   <= i_item_data[24:22];
            r_tailed <= i_item_data[25] & i_item_data[26];
            r_pos    <= i_item_data[58:27];
        end
    end

    always_comb begin
        kind = IK_NONE;
        if (r_cmd) begin
            if (int'(r_vidx) < VOICE_COUNT) begin
                kind = IK_TICK;
            end
        end else begin
            case (r_msg)
                MSG_NOTE_ON:  kind = (r_d2 != 7'd0) ? IK_NOTE_ON : IK_NOTE_OFF;
                MSG_NOTE_OFF: kind = IK_NOTE_OFF;
                MSG_CONTROL:  kind = IK_CONTROL;
                default:      kind = IK_NONE;
            endcase
        end
    end

    // ---------------- controller levels ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sustain <= '0;
            r_steal   <= '0;
        end else if (i_cmd.commit && kind == IK_CONTROL) begin
            if (int'(r_d1) == SUSTAIN_CONTROLLER) begin
                r_sustain <= r_d2;
            end
            if (int'(r_d1) == STEAL_CONTROLLER) begin
                r_steal <= r_d2;
            end
        end
    end

    // ---------------- voice store ----------------
    assign entry    = r_rd_valid ? r_rd_data : '0;
    assign busy     = (entry.state != VS_IDLE);
    assign note_hit = (entry.note == r_d1);

    assign target_addr = (kind == IK_TICK) ? VI_W'(r_vidx) : pick;
    assign rd_en       = i_cmd.scan_read | i_cmd.target_read;
    assign rd_addr     = i_cmd.scan_read ? r_scan_idx : target_addr;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data  <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_eval_idx;
        wr_data = entry;
        if (r_eval && kind == IK_NOTE_OFF && busy && note_hit) begin
            wr_en         = 1'b1;
            wr_data.state = VS_STOPPED;
        end else if (i_cmd.commit && kind == IK_NOTE_ON) begin
            wr_en             = 1'b1;
            wr_addr           = target_addr;
            wr_data.state     = stolen ? VS_RESTARTING : VS_STARTING;
            wr_data.pend_note = r_d1;
            wr_data.pend_vel  = r_d2;
        end else if (i_cmd.commit && kind == IK_TICK) begin
            wr_en   = 1'b1;
            wr_addr = target_addr;
            wr_data = tk_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    // entries never written read as the reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // ---------------- scan ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval       <= 1'b0;
            r_idle_found <= 1'b0;
            r_same_found <= 1'b0;
            r_old_found  <= 1'b0;
        end else begin
            r_eval <= i_cmd.scan_read;
            if (i_cmd.scan_clear) begin
                r_idle_found <= 1'b0;
                r_same_found <= 1'b0;
                r_old_found  <= 1'b0;
            end else if (r_eval && kind == IK_NOTE_ON) begin
                if (!busy) begin
                    r_idle_found <= 1'b1;
                end else begin
                    if (note_hit) begin
                        r_same_found <= 1'b1;
                    end
                    r_old_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clear) begin
            r_scan_idx <= '0;
            r_mask     <= '0;
        end else begin
            if (i_cmd.scan_read) begin
                r_scan_idx <= r_scan_idx + 1'b1;
                r_eval_idx <= r_scan_idx;
            end
            if (r_eval && kind == IK_NOTE_ON) begin
                if (!busy) begin
                    r_idle_idx <= r_eval_idx;
                end else begin
                    if (note_hit) begin
                        r_same_idx <= r_eval_idx;
                    end
                    // strict compare keeps the lowest index on ties
                    if (!r_old_found || entry.age > r_old_age) begin
                        r_old_idx <= r_eval_idx;
                        r_old_age <= entry.age;
                    end
                end
            end
            if (r_eval && kind == IK_NOTE_OFF && busy && note_hit) begin
                r_mask <= r_mask | (8'd1 << r_eval_idx);
            end
        end
    end

    always_comb begin
        if (r_steal != 7'd0 && r_same_found) begin
            pick   = r_same_idx;
            stolen = 1'b1;
        end else if (r_idle_found) begin
            pick   = r_idle_idx;
            stolen = 1'b0;
        end else if (r_old_found) begin
            pick   = r_old_idx;
            stolen = 1'b1;
        end else begin
            pick   = '0;
            stolen = 1'b1;
        end
    end

    // ---------------- tick update ----------------
    always_comb begin
        tk_next     = entry;
        tk_next.age = r_pos;
        tk_start    = 1'b0;
        tk_rel      = 1'b0;
        case (entry.state)
            VS_STARTING: begin
                tk_next.note  = entry.pend_note;
                tk_next.state = VS_RUNNING;
                tk_start      = 1'b1;
            end
            VS_RESTARTING: begin
                if (r_tailed) begin
                    tk_next.state = VS_STARTING;
                end
            end
            VS_STOPPED: begin
                if (r_sustain == 7'd0) begin
                    tk_next.state = VS_RELEASED;
                    tk_rel        = 1'b1;
                end
            end
            VS_RELEASED: begin
                if (r_tailed) begin
                    tk_next.state = VS_IDLE;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- result ----------------
    always_comb begin
        res_event  = EV_IGNORED;
        res_voice  = '0;
        res_stolen = 1'b0;
        res_mask   = '0;
        res_quick  = 1'b0;
        res_start  = 1'b0;
        res_rel    = 1'b0;
        res_state  = '0;
        res_note   = '0;
        res_vel    = '0;
        case (kind)
            IK_NOTE_ON: begin
                res_event  = EV_ASSIGNED;
                res_voice  = 3'(pick);
                res_stolen = stolen;
                res_quick  = stolen;
                res_state  = stolen ? VS_RESTARTING : VS_STARTING;
            end
            IK_NOTE_OFF: begin
                res_event = EV_RELEASED;
                res_mask  = r_mask;
            end
            IK_CONTROL: begin
                res_event = EV_CONTROLLER;
            end
            IK_TICK: begin
                res_event = EV_TICKED;
                res_voice = r_vidx;
                res_start = tk_start;
                res_rel   = tk_rel;
                res_state = tk_next.state;
                if (tk_start) begin
                    res_note = entry.pend_note;
                    res_vel  = entry.pend_vel;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_out_data <= {res_vel, res_note, res_state, res_rel, res_start, res_quick,
                           res_mask, res_stolen, res_voice};
            o_out_user <= res_event;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_status.kind      = kind;
    assign o_status.scan_last = (r_scan_idx == LAST_VOICE);
    assign o_status.out_busy  = r_out_valid & ~i_out_ready;

endmodule

[rtl/synth_voice_allocator_unit.sv]
`timescale 1ns / 1ps
`include "synth_voice_allocator_unit_macros.svh"
// ----------------------------------------------------------------------------
// synth_voice_allocator_unit
// Polyphonic voice allocator: MIDI note/controller messages and voice ticks in,
// one event per transfer out.
//
//   port group   dir   tdata                          tuser
//   s_*          in    MIDI bytes / tick fields       0 MIDI, 1 tick
//   m_*          out   voice, masks, flags, notes     event kind
//
// One item at a time. Controller, ignored and tick items pass through decode
// and commit only; note-off adds a scan of one voice per cycle through the single
// read port of the voice store and a scan-end step, and note-on also a pick step.
// A result waiting in the output register stalls only the commit of the next.
// No clearing pass after reset: per-voice valid bits stand in for it.
// ----------------------------------------------------------------------------
module synth_voice_allocator_unit
    import svau_pkg::*;
#(
    parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [7:0] midi_status, [14:8] midi_data1, [21:15] midi_data2, [24:22] voice_index,
    // [25] env1_stopped, [26] env2_stopped, [58:27] playback_position, [63:59] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [2:0] voice_number, [3] was_stolen, [11:4] stopped_voices,
    // [12] quick_stop_envelopes, [13] start_envelopes, [14] release_envelopes,
    // [17:15] new_voice_state, [24:18] start_note, [31:25] start_velocity
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // [2:0] event_kind
    output logic [EVENT_W-1:0]     m_tuser
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    svau_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    svau_datapath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_item_data (s_tdata[IN_USED_W-1:0]),
        .i_item_user (s_tuser),
        .i_out_ready (m_tready),
        .o_out_valid (m_tvalid),
        .o_out_data  (m_tdata),
        .o_out_user  (m_tuser)
    );

    // one item in flight: input closes right after a transfer
    `SVA_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // envelope start comes only from a tick
    `SVA_IMPLIES(a_start_only_on_tick, m_tvalid && m_tdata[13], m_tuser == EV_TICKED)
    // quick stop goes with a stolen voice
    `SVA_IMPLIES(a_quick_stop_on_steal, m_tvalid, m_tdata[12] == m_tdata[3])

endmodule
